@@ src/debounce_bank_with_toggle_unit_assert.svh @@
// Assertion macros used by the debounce bank top level.
`ifndef DEBOUNCE_BANK_WITH_TOGGLE_UNIT_ASSERT_SVH
`define DEBOUNCE_BANK_WITH_TOGGLE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DBT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("debounce bank check failed");

// The consequent must hold in the cycle after the antecedent.
`define DBT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("debounce bank check failed");

`endif

@@ src/dbt_pkg.sv @@
// Package with the constants and command codes of the debounce bank.
package dbt_pkg;
   localparam int CHANNELS = 6;
   localparam int OUT_BITS = 6;
   localparam int CNT_W = 8;
   localparam int SCAN_W = 32;
   localparam logic [CNT_W-1:0] THRESHOLD_RESET = CNT_W'(3);

   typedef enum logic [1:0] {
      CMD_SCAN = 2'd0,
      CMD_SET_TOGGLE = 2'd1,
      CMD_CLEAR_TOGGLE = 2'd2,
      CMD_RESET_ALL = 2'd3
   } cmd_type;
endpackage

@@ src/debounce_bank_with_toggle_unit.sv @@
// Top level of the debounce bank: six counter debouncers with toggle latches.
// Each accepted request word is processed combinationally and its response word is
// held in an output register; a new request is taken every cycle as long as the
// response register is empty or being read in the same cycle, so the block
// sustains one word per clock and a stalled response holds off new requests.
// A scan word advances every channel's differ counter against the threshold,
// commands one and two write one toggle latch, and command three returns the
// bank and the scan count to their reset values without touching the threshold.
`include "debounce_bank_with_toggle_unit_assert.svh"

module debounce_bank_with_toggle_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [7:0]               csr_wr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  dbt_pkg::cmd_type         req_cmd,
   input  logic [5:0]               req_raw_pins,
   input  logic [2:0]               req_pin_index,
   input  logic                     req_toggle_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [5:0]               rsp_stable_bits,
   output logic [5:0]               rsp_changed_bits,
   output logic [5:0]               rsp_toggle_bits,
   output logic [31:0]              rsp_scan_total
);
   import dbt_pkg::*;

   localparam int EXT_W = (CHANNELS > OUT_BITS) ? CHANNELS : OUT_BITS;

   logic [CNT_W-1:0]    threshold_ff;
   logic [CHANNELS-1:0] stable_ff, stable_in;
   logic [CHANNELS-1:0] previous_ff, previous_in;
   logic [CHANNELS-1:0] toggle_ff, toggle_in;
   logic [CNT_W-1:0]    count_ff [CHANNELS];
   logic [CNT_W-1:0]    count_in [CHANNELS];
   logic [SCAN_W-1:0]   scan_ff, scan_in;

   logic                rsp_valid_ff;
   logic [OUT_BITS-1:0] stable_out_ff, changed_out_ff, toggle_out_ff;
   logic [SCAN_W-1:0]   scan_out_ff;

   logic                accept;
   logic [EXT_W-1:0]    raw_ext;
   logic [EXT_W-1:0]    stable_ext, changed_ext, toggle_ext;
   logic [CNT_W-1:0]    count_inc [CHANNELS];
   logic                index_ok;

   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept = req_valid && req_ready;
   assign raw_ext = EXT_W'(req_raw_pins);
   assign index_ok = 32'(req_pin_index) < CHANNELS;

   always_comb begin
      stable_in = stable_ff;
      previous_in = previous_ff;
      toggle_in = toggle_ff;
      scan_in = scan_ff;
      for (int i = 0; i < CHANNELS; i++) begin
         count_in[i] = count_ff[i];
         count_inc[i] = count_ff[i] + CNT_W'(1);
      end
      unique case (req_cmd)
         CMD_SCAN: begin
            scan_in = scan_ff + SCAN_W'(1);
            for (int i = 0; i < CHANNELS; i++) begin
               if (raw_ext[i] == stable_ff[i]) begin
                  count_in[i] = '0;
               end else if (count_inc[i] >= threshold_ff) begin
                  count_in[i] = '0;
                  previous_in[i] = stable_ff[i];
                  stable_in[i] = raw_ext[i];
                  if (stable_ff[i] && !raw_ext[i]) begin
                     toggle_in[i] = !toggle_ff[i];
                  end
               end else begin
                  count_in[i] = count_inc[i];
               end
            end
         end
         CMD_SET_TOGGLE: begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (index_ok && 32'(req_pin_index) == i) begin
                  toggle_in[i] = req_toggle_value;
               end
            end
         end
         CMD_CLEAR_TOGGLE: begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (index_ok && 32'(req_pin_index) == i) begin
                  toggle_in[i] = 1'b1;
               end
            end
         end
         CMD_RESET_ALL: begin
            stable_in = '1;
            previous_in = '1;
            toggle_in = '1;
            scan_in = '0;
            for (int i = 0; i < CHANNELS; i++) begin
               count_in[i] = '0;
            end
         end
         default: begin
            scan_in = scan_ff;
         end
      endcase
   end

   assign stable_ext = EXT_W'(stable_in);
   assign changed_ext = EXT_W'(stable_in ^ previous_in);
   assign toggle_ext = EXT_W'(toggle_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         stable_ff <= '1;
         previous_ff <= '1;
         toggle_ff <= '1;
         scan_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            count_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            threshold_ff <= csr_wr_data;
         end
         if (accept) begin
            stable_ff <= stable_in;
            previous_ff <= previous_in;
            toggle_ff <= toggle_in;
            scan_ff <= scan_in;
            for (int i = 0; i < CHANNELS; i++) begin
               count_ff[i] <= count_in[i];
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stable_out_ff <= stable_ext[OUT_BITS-1:0];
         changed_out_ff <= changed_ext[OUT_BITS-1:0];
         toggle_out_ff <= toggle_ext[OUT_BITS-1:0];
         scan_out_ff <= scan_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_stable_bits = stable_out_ff;
   assign rsp_changed_bits = changed_out_ff;
   assign rsp_toggle_bits = toggle_out_ff;
   assign rsp_scan_total = scan_out_ff;

   `DBT_ASSERT_NEXT(a_accept_gives_word, clock, reset, accept, rsp_valid)
   `DBT_ASSERT_NOW(a_stall_blocks_input, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `DBT_ASSERT_NEXT(a_scan_counts, clock, reset, accept && req_cmd == CMD_SCAN,
      rsp_scan_total == $past(scan_ff) + SCAN_W'(1))
   `DBT_ASSERT_NEXT(a_reset_cmd_clears, clock, reset, accept && req_cmd == CMD_RESET_ALL,
      rsp_scan_total == '0 && rsp_changed_bits == '0 && stable_ff == '1 && toggle_ff == '1)
endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the six-channel debounce bank with toggle latches.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dbt_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [OUT_BITS-1:0] stable;
      logic [OUT_BITS-1:0] changed;
      logic [OUT_BITS-1:0] toggle;
      logic [SCAN_W-1:0]   scans;
   } bank_view_type;

   class bank_tracker_type;
      bit [CHANNELS-1:0] stable_lvl;
      bit [CHANNELS-1:0] prior_lvl;
      bit [CHANNELS-1:0] toggles;
      bit [CNT_W-1:0]    differ[CHANNELS];
      bit [SCAN_W-1:0]   scans;
      bit [CNT_W-1:0]    threshold;
      bank_view_type     views_due[$];
      int                failures;

      function new();
         threshold = THRESHOLD_RESET;
         failures = 0;
         clear_bank();
      endfunction

      function void clear_bank();
         stable_lvl = '1;
         prior_lvl = '1;
         toggles = '1;
         scans = '0;
         for (int i = 0; i < CHANNELS; i++)
            differ[i] = '0;
      endfunction

      function int pending();
         return views_due.size();
      endfunction

      function void take_word(cmd_type cmd, logic [5:0] raw, logic [2:0] idx, logic tval);
         bank_view_type v;
         case (cmd)
            CMD_SCAN: begin
               for (int i = 0; i < CHANNELS; i++) begin
                  if (raw[i] == stable_lvl[i]) begin
                     differ[i] = '0;
                  end else begin
                     differ[i] = differ[i] + 1'b1;
                     if (differ[i] >= threshold) begin
                        prior_lvl[i] = stable_lvl[i];
                        stable_lvl[i] = raw[i];
                        if (prior_lvl[i] && !raw[i])
                           toggles[i] = ~toggles[i];
                        differ[i] = '0;
                     end
                  end
               end
               scans = scans + 1'b1;
            end
            CMD_SET_TOGGLE: begin
               if (idx < CHANNELS)
                  toggles[idx] = tval;
            end
            CMD_CLEAR_TOGGLE: begin
               if (idx < CHANNELS)
                  toggles[idx] = 1'b1;
            end
            default: clear_bank();
         endcase
         v.stable = stable_lvl;
         v.changed = stable_lvl ^ prior_lvl;
         v.toggle = toggles;
         v.scans = scans;
         views_due.push_back(v);
      endfunction

      function void match_view(logic [5:0] stable, logic [5:0] changed, logic [5:0] toggle,
                               logic [31:0] total);
         bank_view_type v;
         if (views_due.size() == 0) begin
            $display("%0t: response word with none outstanding", $time);
            failures++;
            return;
         end
         v = views_due.pop_front();
         if (stable !== v.stable) begin
            $display("%0t: stable_bits expected %h actual %h", $time, v.stable, stable);
            failures++;
         end
         if (changed !== v.changed) begin
            $display("%0t: changed_bits expected %h actual %h", $time, v.changed, changed);
            failures++;
         end
         if (toggle !== v.toggle) begin
            $display("%0t: toggle_bits expected %h actual %h", $time, v.toggle, toggle);
            failures++;
         end
         if (total !== v.scans) begin
            $display("%0t: scan_total expected %h actual %h", $time, v.scans, total);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;
   logic        req_valid;
   logic        req_ready;
   cmd_type     req_cmd;
   logic [5:0]  req_raw_pins;
   logic [2:0]  req_pin_index;
   logic        req_toggle_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [5:0]  rsp_stable_bits;
   logic [5:0]  rsp_changed_bits;
   logic [5:0]  rsp_toggle_bits;
   logic [31:0] rsp_scan_total;

   bank_tracker_type bank;
   int          cycle_count = 0;
   bit          steady = 1'b0;
   bit          long_hold = 1'b0;

   debounce_bank_with_toggle_unit DUT (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_raw_pins(req_raw_pins),
      .req_pin_index(req_pin_index),
      .req_toggle_value(req_toggle_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_stable_bits(rsp_stable_bits),
      .rsp_changed_bits(rsp_changed_bits),
      .rsp_toggle_bits(rsp_toggle_bits),
      .rsp_scan_total(rsp_scan_total)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            bank.match_view(rsp_stable_bits, rsp_changed_bits, rsp_toggle_bits, rsp_scan_total);
         if (req_valid && req_ready)
            bank.take_word(req_cmd, req_raw_pins, req_pin_index, req_toggle_value);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   // The receiver draws its own stalls; a long hold-off is requested by the sender.
   initial begin
      int stall_left;
      int r;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (long_hold) begin
            long_hold = 1'b0;
            stall_left = 80;
            rsp_ready <= 1'b0;
         end else if (steady) begin
            rsp_ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_ready <= 1'b1;
            end else if (r < 95) begin
               rsp_ready <= 1'b0;
               stall_left = $urandom_range(0, 3);
            end else begin
               rsp_ready <= 1'b0;
               stall_left = $urandom_range(10, 40);
            end
         end
      end
   end

   task automatic send_word(input cmd_type cmd, input logic [5:0] raw, input logic [2:0] idx,
                            input logic tval);
      int gap;
      int r;
      gap = 0;
      if (!steady) begin
         r = $urandom_range(0, 99);
         if (r >= 95)
            gap = $urandom_range(8, 40);
         else if (r >= 70)
            gap = $urandom_range(1, 3);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_raw_pins <= raw;
      req_pin_index <= idx;
      req_toggle_value <= tval;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   task automatic drain_bank();
      @(negedge clock);
      req_valid <= 1'b0;
      while (bank.pending() != 0)
         @(posedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [7:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      bank.threshold = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic scan_run(input logic [5:0] raw, input int count);
      repeat (count) send_word(CMD_SCAN, raw, 3'd0, 1'b0);
   endtask

   // Mostly runs of one pin pattern long enough to debounce, with some noise.
   task automatic random_phase(input logic [7:0] thr, input int items, input int hold_at,
                               input int pause_at);
      logic [5:0] target;
      int         run_left;
      int         eff;
      int         r;
      bit         quiet;
      eff = (thr == 0) ? 1 : int'(thr);
      quiet = (eff > 20);
      target = $urandom_range(0, 63);
      run_left = 0;
      for (int n = 0; n < items; n++) begin
         if (n % 50 == 0)
            steady = ($urandom_range(0, 3) == 0);
         if (n == hold_at)
            long_hold = 1'b1;
         if (n == pause_at)
            drain_bank();
         if (run_left == 0) begin
            target = target ^ 6'($urandom_range(1, 63));
            if ($urandom_range(0, 9) < 3)
               run_left = $urandom_range(1, eff);
            else
               run_left = $urandom_range(eff, eff + 3);
         end
         r = $urandom_range(0, 99);
         if (r < 80 || (quiet && r < 97)) begin
            send_word(CMD_SCAN, target, 3'd0, 1'($urandom_range(0, 1)));
            run_left--;
         end else if (!quiet && r < 86) begin
            send_word(CMD_SCAN, 6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)), 1'b0);
         end else if (r < 92 || (quiet && r < 99)) begin
            send_word(CMD_SET_TOGGLE, 6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)),
                      1'($urandom_range(0, 1)));
         end else if (r < 98 || quiet) begin
            send_word(CMD_CLEAR_TOGGLE, 6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)),
                      1'($urandom_range(0, 1)));
         end else begin
            send_word(CMD_RESET_ALL, 6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)),
                      1'($urandom_range(0, 1)));
         end
      end
      steady = 1'b0;
      drain_bank();
   endtask

   initial begin
      bank = new();
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 8'd0;
      req_valid = 1'b0;
      req_cmd = CMD_SCAN;
      req_raw_pins = 6'd0;
      req_pin_index = 3'd0;
      req_toggle_value = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Default threshold: fall on every pin, toggle writes, ignored indexes, rise.
      send_word(CMD_SCAN, 6'h3f, 3'd0, 1'b0);
      scan_run(6'h00, 3);
      send_word(CMD_SET_TOGGLE, 6'h00, 3'd0, 1'b1);
      send_word(CMD_SET_TOGGLE, 6'h00, 3'd5, 1'b1);
      send_word(CMD_SET_TOGGLE, 6'h3f, 3'd6, 1'b0);
      send_word(CMD_CLEAR_TOGGLE, 6'h3f, 3'd7, 1'b1);
      send_word(CMD_CLEAR_TOGGLE, 6'h00, 3'd3, 1'b0);
      scan_run(6'h3f, 3);
      send_word(CMD_SCAN, 6'h15, 3'd0, 1'b0);
      send_word(CMD_SCAN, 6'h3f, 3'd0, 1'b0);
      send_word(CMD_SET_TOGGLE, 6'h00, 3'd2, 1'b0);
      send_word(CMD_RESET_ALL, 6'h2a, 3'd4, 1'b1);
      drain_bank();

      // Counters carry into a lower threshold.
      write_threshold(8'd10);
      scan_run(6'h00, 5);
      drain_bank();
      write_threshold(8'd2);
      send_word(CMD_SCAN, 6'h00, 3'd0, 1'b0);
      drain_bank();

      // A zero threshold behaves as one.
      write_threshold(8'd0);
      send_word(CMD_SCAN, 6'h0f, 3'd0, 1'b0);
      send_word(CMD_SCAN, 6'h3f, 3'd0, 1'b0);
      drain_bank();

      write_threshold(8'd1);
      random_phase(8'd1, 150, -1, -1);
      write_threshold(8'd2);
      random_phase(8'd2, 150, 60, -1);
      write_threshold(8'd5);
      random_phase(8'd5, 150, -1, 75);
      write_threshold(8'd0);
      random_phase(8'd0, 150, -1, -1);
      begin
         logic [7:0] thr;
         thr = $urandom_range(3, 20);
         write_threshold(thr);
         random_phase(thr, 150, 100, -1);
      end
      write_threshold(8'd255);
      random_phase(8'd255, 500, -1, -1);

      repeat (5) @(posedge clock);
      if (bank.failures == 0 && bank.pending() == 0) begin
         $display("tb: success");
      end else begin
         if (bank.pending() != 0)
            $display("%0t: %0d response words never arrived", $time, bank.pending());
         $display("tb: failure");
      end
      $finish;
   end
endmodule
